### design/xnhd_pkg.sv
// ----------------------------------------------------------------------------
// xnhd_pkg
// Shared types, character codes and helpers of the name hex-escape decoder.
// ----------------------------------------------------------------------------
package xnhd_pkg;

  // held bytes of the lookahead window (the seventh byte is the incoming one)
  localparam int unsigned HeldDepth = 6;
  // middle bytes of an escape run
  localparam int unsigned FieldLen  = 4;

  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam logic [7:0] CharLowerX     = 8'h78;
  localparam logic [7:0] CharUpperX     = 8'h58;
  localparam logic [7:0] CharPlus       = 8'h2B;
  localparam logic [7:0] CharMinus      = 8'h2D;
  localparam logic [7:0] CharZero       = 8'h30;
  localparam logic [7:0] CharNine       = 8'h39;
  localparam logic [7:0] CharLowerA     = 8'h61;
  localparam logic [7:0] CharLowerF     = 8'h66;
  localparam logic [7:0] CharUpperA     = 8'h41;
  localparam logic [7:0] CharUpperF     = 8'h46;
  localparam logic [7:0] CharSpace      = 8'h20;
  localparam logic [7:0] CharTab        = 8'h09;
  localparam logic [7:0] CharCr         = 8'h0D;
  localparam logic [7:0] EscMaxVal      = 8'h7F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_req_t;

  // contents of one window cell
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } cell_data_t;

  // control shared by every cell of the row
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CharZero) && (c <= CharNine)) ||
           ((c >= CharLowerA) && (c <= CharLowerF)) ||
           ((c >= CharUpperA) && (c <= CharUpperF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= CharZero) && (c <= CharNine)) begin
      v = c - CharZero;
    end else if ((c >= CharLowerA) && (c <= CharLowerF)) begin
      v = c - CharLowerA + 8'd10;
    end else if ((c >= CharUpperA) && (c <= CharUpperF)) begin
      v = c - CharUpperA + 8'd10;
    end else begin
      v = 8'd0;
    end
    return v[3:0];
  endfunction

endpackage

### design/xml_name_hex_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// xml_name_hex_escape_decoder_core
// Streams a name byte by byte and folds _xHHHH_ runs into single bytes.
// ----------------------------------------------------------------------------
// output: results are held in a registered output stage
// throughput: one request per cycle while the name streams in and the output is not stalled
// flush: after a request with in_last that leaves bytes in the window, the six
//   window cells drain one per cycle while the output is not stalled, and no
//   request is taken until the window is empty
// reset: window and output register empty, no flush pending
module xml_name_hex_escape_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  xnhd_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output xnhd_pkg::out_req_t out_req_o
);
  import xnhd_pkg::*;

  // window cells, cell 0 holds the oldest byte; outside a flush valid bytes sit right-aligned
  cell_data_t cell_q  [HeldDepth];
  cell_data_t cell_in [HeldDepth];
  cell_data_t insert;
  cell_ctrl_t cell_ctrl;

  logic [HeldDepth-1:0] vld_vec;
  logic [7:0]           field [FieldLen];

  logic       flush_q, flush_d;
  logic       out_valid_q, out_valid_d;
  out_req_t   out_q, out_d;

  logic       adv;
  logic       in_acc;
  logic       full;
  logic       field_ok;
  logic [7:0] esc_val;
  logic       esc_hit;

  // ---- cell row, each cell loads from its right neighbor ----
  for (genvar k = 0; k < HeldDepth; k++) begin : g_cell
    if (k == HeldDepth - 1) begin : g_tail
      assign cell_in[k] = insert;
    end else begin : g_link
      assign cell_in[k] = cell_q[k+1];
    end

    xnhd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .nb_i   (cell_in[k]),
      .cell_o (cell_q[k])
    );

    assign vld_vec[k] = cell_q[k].vld;
  end

  // ---- escape test on the seven-byte window ----
  for (genvar k = 0; k < FieldLen; k++) begin : g_field
    assign field[k] = cell_q[k+2].data;
  end

  xnhd_field_parse u_parse (
    .field_i (field),
    .ok_o    (field_ok),
    .value_o (esc_val)
  );

  // window is full when the oldest cell holds a byte
  assign full    = vld_vec[0];
  assign esc_hit = full &&
                   (cell_q[0].data == CharUnderscore) &&
                   ((cell_q[1].data == CharLowerX) || (cell_q[1].data == CharUpperX)) &&
                   (in_req_i.in_byte == CharUnderscore) &&
                   field_ok;

  // ---- handshake ----
  // output register frees up when empty or taken this cycle
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv && !flush_q;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d     = out_valid_q;
    out_d           = out_q;
    flush_d         = flush_q;
    cell_ctrl.shift = 1'b0;
    cell_ctrl.clear = 1'b0;
    insert.vld      = 1'b0;
    insert.data     = in_req_i.in_byte;
    priority if (in_acc) begin
      // new byte enters the tail; a full window emits its head or the escape
      cell_ctrl.shift = 1'b1;
      cell_ctrl.clear = esc_hit;
      insert.vld      = 1'b1;
      out_valid_d     = full;
      out_d.out_byte  = esc_hit ? esc_val : cell_q[0].data;
      out_d.out_last  = esc_hit && in_req_i.in_last;
      // a hit with in_last leaves nothing behind
      flush_d         = in_req_i.in_last && !esc_hit;
    end else if (flush_q && adv) begin
      // drain: shift empties in at the tail, emit whatever reaches the head
      cell_ctrl.shift = 1'b1;
      out_valid_d     = vld_vec[0];
      out_d.out_byte  = cell_q[0].data;
      out_d.out_last  = ~|vld_vec[HeldDepth-1:1];
      flush_d         = |vld_vec[HeldDepth-1:1];
    end else if (adv) begin
      out_valid_d = 1'b0;
    end else begin
      // output stalled, hold everything
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      flush_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      flush_q     <= flush_d;
    end
  end

  // output payload, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // ---- assertions ----
  // outside a flush the held bytes sit right-aligned in the row
  a_vld_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flush_q |-> ((vld_vec[HeldDepth-2:0] & ~vld_vec[HeldDepth-1:1]) == '0))
    else $error("window valid bits not right-aligned");

  // an escape hit empties the whole window
  a_hit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && esc_hit) |=> (vld_vec == '0))
    else $error("window not empty after escape hit");

  // a pending flush always has bytes left to drain
  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> (vld_vec != '0))
    else $error("flush pending on empty window");

  // loading the final result ends the flush
  a_last_ends_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && out_valid_d && out_d.out_last) |=> !flush_q)
    else $error("flush still pending after final result");

endmodule

### design/xnhd_cell.sv
// ----------------------------------------------------------------------------
// xnhd_cell
// One byte cell of the lookahead window, loaded from its right neighbor.
// ----------------------------------------------------------------------------
module xnhd_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xnhd_pkg::cell_ctrl_t ctrl_i,
  input  xnhd_pkg::cell_data_t nb_i,
  output xnhd_pkg::cell_data_t cell_o
);
  import xnhd_pkg::*;

  logic       vld_q;
  logic [7:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      vld_q <= nb_i.vld & ~ctrl_i.clear;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      data_q <= nb_i.data;
    end
  end

  assign cell_o.vld  = vld_q;
  assign cell_o.data = data_q;

endmodule

### design/xnhd_field_parse.sv
// ----------------------------------------------------------------------------
// xnhd_field_parse
// Checks the four middle bytes of an escape as a base-16 number up to 0x7F.
// ----------------------------------------------------------------------------
module xnhd_field_parse (
  input  logic [7:0] field_i [xnhd_pkg::FieldLen],
  output logic       ok_o,
  output logic [7:0] value_o
);
  import xnhd_pkg::*;

  logic [2:0]  len;
  logic        found;
  logic [2:0]  pos;
  logic        skip;
  logic        neg;
  logic        all_hex;
  logic [15:0] acc;

  always_comb begin
    // field ends at the first zero byte
    len   = 3'(FieldLen);
    found = 1'b0;
    for (int k = 0; k < FieldLen; k++) begin
      if (!found && (field_i[k] == 8'd0)) begin
        len   = 3'(k);
        found = 1'b1;
      end
    end

    // leading blanks
    pos  = 3'd0;
    skip = 1'b1;
    for (int k = 0; k < FieldLen; k++) begin
      if (skip) begin
        if ((3'(k) < len) && is_blank(field_i[k])) begin
          pos = 3'(k + 1);
        end else begin
          skip = 1'b0;
        end
      end
    end

    // optional sign
    neg = 1'b0;
    if ((pos < len) &&
        ((field_i[2'(pos)] == CharPlus) || (field_i[2'(pos)] == CharMinus))) begin
      neg = (field_i[2'(pos)] == CharMinus);
      pos = pos + 3'd1;
    end

    // 0x prefix only when a hex digit follows
    if (((pos + 3'd2) < len) && (field_i[2'(pos)] == CharZero) &&
        ((field_i[2'(pos + 3'd1)] == CharLowerX) ||
         (field_i[2'(pos + 3'd1)] == CharUpperX)) &&
        is_hex(field_i[2'(pos + 3'd2)])) begin
      pos = pos + 3'd2;
    end

    // digits must run to the end of the field
    all_hex = 1'b1;
    acc     = 16'd0;
    for (int k = 0; k < FieldLen; k++) begin
      if ((3'(k) >= pos) && (3'(k) < len)) begin
        if (is_hex(field_i[k])) begin
          acc = {acc[11:0], hex_val(field_i[k])};
        end else begin
          all_hex = 1'b0;
        end
      end
    end

    ok_o    = (len == 3'd0) ||
              ((pos < len) && all_hex && (!neg || (acc == 16'd0)) &&
               (acc <= 16'(EscMaxVal)));
    value_o = (len == 3'd0) ? 8'd0 : {1'b0, acc[6:0]};
  end

endmodule
